// File: sv/psa_pkg.sv
// Package with constants, types and helpers of the priority scheduler with aging.
`default_nettype none
package psa_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam logic [15:0] WAIT_LIMIT_RST = 16'd20;
    localparam logic [7:0] PERIOD_RST = 8'd10;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic CFG_WAIT_LIMIT = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Task table entry: arrival, burst, remaining, priority, started, first run.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  priority_num;
        logic        started;
        logic [15:0] first_run;
    } task_t;

    localparam int TASK_W = $bits(task_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_RD,
        ST_SEL,
        ST_RUN_RD,
        ST_RUN_RD2,
        ST_RUN,
        ST_RUN_WR,
        ST_AGE_RD,
        ST_AGE,
        ST_MOD,
        ST_DONE_RD,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: sv/priority_scheduler_aging.sv
// Top level of the preemptive priority scheduler with aging.
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: operation, slot, arrival_tick, burst_ticks, start_priority
//  m_axis   | out       | tdata: time_after .. all_done (one transfer per tick item)
//  cfg      | in        | cfg_we, cfg_index, cfg_data (0 wait limit, 1 aging period)
//
// A load item is written into the task RAM as it is taken. A tick item keeps the block busy
// after its transfer (N = NUM_TASKS) through the selection pass, the run update, the periodic
// aging pass (sixteen remainder steps per entry) and the all-done scan, and then loads the
// output register. A new item is taken only once the block is back in idle.
// After reset a clearing pass over all N entries empties the task RAM before items are taken.
// The result waits in an output register; a later tick holds before its output cycle
// until that register has been emptied.
`default_nettype none
module priority_scheduler_aging
    import psa_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] operation, [3:1] slot, [19:4] arrival_tick, [35:20] burst_ticks,
    // [43:36] start_priority, [47:44] zero
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] time_after, [18:16] running_slot, [19] idle, [20] preempted,
    // [21] switched, [22] completed, [38:23] turnaround, [54:39] waiting,
    // [70:55] response, [71] all_done
    output logic [71:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [15:0] wait_limit_reg;
    logic [7:0]  period_reg;
    state_t      state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        clr_reg;
    logic [CW-1:0] clr_idx_reg;

    logic [15:0] time_reg;
    logic        run_valid_reg;
    logic [IW-1:0] run_idx_reg;
    logic        prev_valid_reg;
    logic [2:0]  prev_slot_reg;
    logic        found_reg;
    logic [IW-1:0] sel_reg;
    logic [7:0]  sel_pri_reg;
    logic        preempt_reg, run_ok_reg, sw_reg, done_reg, alldone_reg;
    logic [15:0] tat_reg, wt_reg, rsp_reg;
    logic [IW-1:0] run_slot_reg;
    logic [15:0] age_reg;
    logic [7:0]  rem_reg;
    logic [4:0]  bit_reg;
    task_t       ent_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    task_t         wdata, rdata;

    psa_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_tasks (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic accept;
    logic [2:0] in_slot;
    logic ready_sel, aged_sel;
    logic [15:0] t_new;
    logic take_sel;
    logic out_free;
    logic [8:0] rem_trial;
    task_t run_ent;

    assign s_axis_tready = (state_reg == ST_IDLE) && !clr_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_slot = s_axis_tdata[3:1];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign t_new = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 16'd1;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rem_trial = {rem_reg, age_reg[15]};

    assign ready_sel = (rdata.remaining != 16'd0) && (rdata.arrival <= time_reg);
    assign aged_sel = ready_sel && (rdata.priority_num > 8'd1)
                      && ((time_reg - rdata.arrival) > wait_limit_reg);

    logic [7:0] pri_sel;
    assign pri_sel = aged_sel ? rdata.priority_num - 8'd1 : rdata.priority_num;

    // With rdata holding the running entry, decides whether the selected task runs next.
    assign take_sel = run_valid_reg
                      ? (found_reg && sel_reg != run_idx_reg && rdata.remaining != 16'd0
                         && sel_pri_reg < rdata.priority_num)
                      : found_reg;

    always_comb
    begin
        run_ent = rdata;
        run_ent.started = 1'b1;
        if (!rdata.started) run_ent.first_run = time_reg;
        run_ent.remaining = rdata.remaining - 16'd1;
    end

    logic last_idx;
    assign last_idx = (idx_reg == CW'(NUM_TASKS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept && s_axis_tdata[0] == OP_TICK) state_next = ST_SEL_RD;
            ST_SEL_RD:  state_next = ST_SEL;
            ST_SEL:     state_next = last_idx ? ST_RUN_RD : ST_SEL_RD;
            ST_RUN_RD:  state_next = ST_RUN_RD2;
            ST_RUN_RD2: state_next = ST_RUN;
            ST_RUN:     state_next = ST_RUN_WR;
            ST_RUN_WR:  state_next = ST_AGE_RD;
            ST_AGE_RD:  state_next = ST_AGE;
            ST_AGE:     state_next = ST_MOD;
            ST_MOD:
            begin
                if (bit_reg != 5'd0) state_next = ST_MOD;
                else state_next = last_idx ? ST_DONE_RD : ST_AGE_RD;
            end
            ST_DONE_RD: state_next = ST_DONE;
            ST_DONE:    state_next = last_idx ? ST_OUT : ST_DONE_RD;
            ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // RAM addressing and writes.
    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg[IW-1:0];
        wdata = ent_reg;
        raddr = idx_reg[IW-1:0];
        idx_next = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (clr_reg)
                begin
                    we = 1'b1;
                    waddr = clr_idx_reg[IW-1:0];
                    wdata = '0;
                end
                else if (accept && s_axis_tdata[0] == OP_LOAD && int'(in_slot) < NUM_TASKS)
                begin
                    we = 1'b1;
                    waddr = IW'(in_slot);
                    wdata.arrival = s_axis_tdata[19:4];
                    wdata.burst = s_axis_tdata[35:20];
                    wdata.remaining = s_axis_tdata[35:20];
                    wdata.priority_num = s_axis_tdata[43:36];
                    wdata.started = 1'b0;
                    wdata.first_run = '0;
                end
            end
            ST_SEL:
            begin
                we = aged_sel;
                wdata = rdata;
                wdata.priority_num = pri_sel;
                idx_next = last_idx ? '0 : idx_reg + CW'(1);
            end
            ST_RUN_RD:  raddr = run_idx_reg;
            ST_RUN_RD2: raddr = take_sel ? sel_reg : run_idx_reg;
            ST_RUN_WR:
            begin
                waddr = run_slot_reg;
                we = run_ok_reg;
                wdata = ent_reg;
            end
            ST_MOD:
            begin
                if (bit_reg == 5'd0)
                begin
                    we = (rem_reg == 8'd0) && ent_reg.priority_num > 8'd1
                         && ent_reg.remaining != 16'd0 && ent_reg.arrival <= time_reg
                         && period_reg != 8'd0;
                    wdata.priority_num = ent_reg.priority_num - 8'd1;
                    idx_next = last_idx ? '0 : idx_reg + CW'(1);
                end
            end
            ST_DONE:    idx_next = last_idx ? '0 : idx_reg + CW'(1);
            default:    ;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            clr_reg <= 1'b1;
            clr_idx_reg <= '0;
            wait_limit_reg <= WAIT_LIMIT_RST;
            period_reg <= PERIOD_RST;
            time_reg <= '0;
            run_valid_reg <= 1'b0;
            run_idx_reg <= '0;
            prev_valid_reg <= 1'b0;
            prev_slot_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WAIT_LIMIT) wait_limit_reg <= cfg_data;
                else period_reg <= cfg_data[7:0];
            end
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + CW'(1);
                if (clr_idx_reg == CW'(NUM_TASKS - 1)) clr_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    found_reg <= 1'b0;
                    if (accept && s_axis_tdata[0] == OP_LOAD && run_valid_reg
                        && int'(in_slot) == int'(run_idx_reg))
                        run_valid_reg <= 1'b0;
                end
                ST_SEL:
                begin
                    if (ready_sel && (!found_reg || pri_sel < sel_pri_reg))
                    begin
                        found_reg <= 1'b1;
                        sel_reg <= idx_reg[IW-1:0];
                        sel_pri_reg <= pri_sel;
                    end
                end
                ST_RUN_RD2:
                begin
                    // rdata holds the running entry (after selection aging).
                    preempt_reg <= run_valid_reg && take_sel;
                    if (take_sel)
                    begin
                        run_valid_reg <= 1'b1;
                        run_idx_reg <= sel_reg;
                    end
                    else if (run_valid_reg && rdata.remaining == 16'd0)
                        run_valid_reg <= 1'b0;
                end
                ST_RUN:
                begin
                    // Second read returns the chosen entry; the selected one is ready,
                    // so its remaining count is nonzero.
                    ent_reg <= run_ent;
                    run_ok_reg <= run_valid_reg;
                    run_slot_reg <= run_idx_reg;
                    done_reg <= 1'b0;
                    tat_reg <= '0;
                    wt_reg <= '0;
                    rsp_reg <= '0;
                    sw_reg <= 1'b0;
                    if (run_valid_reg)
                    begin
                        if (rdata.remaining == 16'd1)
                        begin
                            done_reg <= 1'b1;
                            tat_reg <= t_new - rdata.arrival;
                            wt_reg <= ((t_new - rdata.arrival) >= rdata.burst)
                                      ? (t_new - rdata.arrival) - rdata.burst : 16'd0;
                            rsp_reg <= (rdata.started ? rdata.first_run : time_reg)
                                       - rdata.arrival;
                            run_valid_reg <= 1'b0;
                        end
                        sw_reg <= prev_valid_reg && (prev_slot_reg != 3'(run_idx_reg));
                        prev_valid_reg <= 1'b1;
                        prev_slot_reg <= 3'(run_idx_reg);
                    end
                    else
                        prev_valid_reg <= 1'b0;
                    time_reg <= t_new;
                end
                ST_AGE:
                begin
                    ent_reg <= rdata;
                    age_reg <= time_reg - rdata.arrival;
                    rem_reg <= '0;
                    bit_reg <= 5'd16;
                end
                ST_MOD:
                begin
                    // Restoring remainder of the age by the period, one bit a cycle.
                    if (bit_reg != 5'd0)
                    begin
                        rem_reg <= (rem_trial >= {1'b0, period_reg})
                                   ? 8'(rem_trial - {1'b0, period_reg}) : rem_trial[7:0];
                        age_reg <= {age_reg[14:0], 1'b0};
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                ST_DONE_RD: alldone_reg <= (idx_reg == '0) ? 1'b1 : alldone_reg;
                ST_DONE:    if (rdata.remaining != 16'd0) alldone_reg <= 1'b0;
                ST_OUT:
                begin
                    if (out_free)
                        out_data_reg <= {alldone_reg, rsp_reg, wt_reg, tat_reg, done_reg,
                                         sw_reg, preempt_reg, !run_ok_reg,
                                         run_ok_reg ? 3'(run_slot_reg) : 3'd0, time_reg};
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/psa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
